// ===== hdl/rau_pkg.sv =====
package rau_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int PROD_W = 2 * OPERAND_WIDTH;
  localparam int RAW_W = 2 * OPERAND_WIDTH + 1;
  localparam int MAG_W = 2 * OPERAND_WIDTH;
  localparam int OUT_W = 33;
  localparam int CNT_W = $clog2(MAG_W);
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_SUB = 2'd1;
  localparam logic [1:0] ACT_MUL = 2'd2;
  localparam logic [1:0] ACT_DIV = 2'd3;

  typedef logic signed [OPERAND_WIDTH-1:0] operand_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    logic signed [RAW_W-1:0] rn;
    logic signed [RAW_W-1:0] rd;
  } raw_t;

endpackage

// ===== hdl/rau_if.sv =====
interface rau_in_if;
  import rau_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] action;
  operand_t a_num;
  operand_t a_den;
  operand_t b_num;
  operand_t b_den;
  modport source(output valid, action, a_num, a_den, b_num, b_den, input ready);
  modport sink(input valid, action, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  import rau_pkg::*;
  logic valid;
  logic ready;
  logic signed [OUT_W-1:0] res_num;
  logic signed [OUT_W-1:0] res_den;
  logic error;
  modport source(output valid, res_num, res_den, error, input ready);
  modport sink(input valid, res_num, res_den, error, output ready);
endinterface

// ===== hdl/rau_front.sv =====
module rau_front (
  input  logic          clk,
  input  logic          rst_n,
  rau_in_if.sink        in_req,
  output logic          push_valid,
  input  logic          push_ready,
  output rau_pkg::raw_t push_data
);
  import rau_pkg::*;

  logic vld_r, vld_nxt;
  logic sub_r;
  prod_t p1_r, p2_r, p3_r;
  operand_t m1a, m1b, m3b;
  logic accept;

  assign in_req.ready = !vld_r || push_ready;
  assign accept = in_req.valid && in_req.ready;

  always_comb begin
    m1a = in_req.a_num;
    m1b = (in_req.action == ACT_MUL) ? in_req.b_num : in_req.b_den;
    m3b = (in_req.action == ACT_DIV) ? in_req.b_num : in_req.b_den;
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (push_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_r <= prod_t'(m1a) * prod_t'(m1b);
      p2_r <= (in_req.action == ACT_ADD || in_req.action == ACT_SUB) ?
              prod_t'(in_req.b_num) * prod_t'(in_req.a_den) : '0;
      p3_r <= prod_t'(in_req.a_den) * prod_t'(m3b);
      sub_r <= (in_req.action == ACT_SUB);
    end
  end

  always_comb begin
    push_valid = vld_r;
    push_data.rn = sub_r ? (RAW_W'(p1_r) - RAW_W'(p2_r)) : (RAW_W'(p1_r) + RAW_W'(p2_r));
    push_data.rd = RAW_W'(p3_r);
  end

endmodule

// ===== hdl/rau_queue.sv =====
module rau_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  rau_pkg::raw_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output rau_pkg::raw_t pop_data
);
  import rau_pkg::*;

  raw_t mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic do_push, do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH)) else $error("queue count beyond depth");

endmodule

// ===== hdl/rau_back.sv =====
module rau_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  rau_pkg::raw_t pop_data,
  rau_out_if.source     out_res
);
  import rau_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EUC  = 3'd1;
  localparam logic [2:0] ST_REM  = 3'd2;
  localparam logic [2:0] ST_DIVN = 3'd3;
  localparam logic [2:0] ST_DIVD = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [MAG_W-1:0] xm_r, ym_r, nm_r, dm_r, qn_r, q_r, rem_r, dv_r;
  logic xs_r, ys_r, ns_r, ds_r, err_r;
  logic [CNT_W-1:0] cnt_r;
  logic signed [OUT_W-1:0] res_num_r, res_den_r;
  logic [MAG_W:0] trial;
  logic ge;
  logic [MAG_W-1:0] rem_step, q_step;
  logic [OUT_W-1:0] qn_ext, qd_ext;

  assign pop_ready = (state_r == ST_IDLE);
  assign out_res.valid = out_valid_r;
  assign out_res.res_num = res_num_r;
  assign out_res.res_den = res_den_r;
  assign out_res.error = err_r;

  always_comb begin
    trial = {rem_r, q_r[MAG_W-1]};
    ge = (trial >= {1'b0, dv_r});
    rem_step = ge ? MAG_W'(trial - {1'b0, dv_r}) : MAG_W'(trial);
    q_step = {q_r[MAG_W-2:0], ge};
    qn_ext = OUT_W'(qn_r);
    qd_ext = OUT_W'(q_step);
  end

  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r;
    unique case (state_r)
      ST_IDLE: if (pop_valid) state_nxt = ST_EUC;
      ST_EUC: begin
        if (ym_r != '0) begin
          state_nxt = ST_REM;
        end else if (xm_r != '0) begin
          state_nxt = ST_DIVN;
        end else begin
          state_nxt = ST_OUT;
          out_valid_nxt = 1'b1;
        end
      end
      ST_REM: if (cnt_r == '0) state_nxt = ST_EUC;
      ST_DIVN: if (cnt_r == '0) state_nxt = ST_DIVD;
      ST_DIVD: begin
        if (cnt_r == '0) begin
          state_nxt = ST_OUT;
          out_valid_nxt = 1'b1;
        end
      end
      ST_OUT: begin
        if (out_res.ready) begin
          state_nxt = ST_IDLE;
          out_valid_nxt = 1'b0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          ns_r <= pop_data.rn[RAW_W-1];
          ds_r <= pop_data.rd[RAW_W-1];
          nm_r <= MAG_W'(pop_data.rn[RAW_W-1] ? -pop_data.rn : pop_data.rn);
          dm_r <= MAG_W'(pop_data.rd[RAW_W-1] ? -pop_data.rd : pop_data.rd);
          xs_r <= pop_data.rn[RAW_W-1];
          ys_r <= pop_data.rd[RAW_W-1];
          xm_r <= MAG_W'(pop_data.rn[RAW_W-1] ? -pop_data.rn : pop_data.rn);
          ym_r <= MAG_W'(pop_data.rd[RAW_W-1] ? -pop_data.rd : pop_data.rd);
        end
      end
      ST_EUC: begin
        rem_r <= '0;
        cnt_r <= CNT_W'(MAG_W - 1);
        if (ym_r != '0) begin
          q_r <= xm_r;
          dv_r <= ym_r;
        end else begin
          q_r <= nm_r;
          dv_r <= xm_r;
          res_num_r <= '0;
          res_den_r <= '0;
          err_r <= (xm_r == '0);
        end
      end
      ST_REM: begin
        rem_r <= rem_step;
        q_r <= q_step;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          xm_r <= ym_r;
          xs_r <= ys_r;
          ym_r <= rem_step;
          ys_r <= xs_r;
        end
      end
      ST_DIVN: begin
        if (cnt_r == '0) begin
          qn_r <= q_step;
          q_r <= dm_r;
          rem_r <= '0;
          cnt_r <= CNT_W'(MAG_W - 1);
        end else begin
          rem_r <= rem_step;
          q_r <= q_step;
          cnt_r <= cnt_r - 1'b1;
        end
      end
      ST_DIVD: begin
        rem_r <= rem_step;
        q_r <= q_step;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          res_num_r <= (ns_r ^ xs_r) ? -qn_ext : qn_ext;
          res_den_r <= (ds_r ^ xs_r) ? -qd_ext : qd_ext;
          err_r <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && err_r) |-> (res_num_r == '0 && res_den_r == '0))
    else $error("error result carries nonzero values");

  a_rem_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REM || state_r == ST_DIVN || state_r == ST_DIVD) |-> (dv_r != '0))
    else $error("division started with zero divisor");

  a_valid_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_OUT)) else $error("result shown outside output state");

endmodule

// ===== hdl/rational_arithmetic_unit.sv =====
// An item passes the front register and the queue, then Euclid remainder steps
// (each one bit-serial division plus a check), then a final check and the two
// exact bit-serial divisions; a raw zero over zero ends after the check.
// One item is reduced at a time; throughput is set by the shared bit-serial divider.
// Reset is synchronous and active low; it empties the queue and clears all valid flags.
module rational_arithmetic_unit (
  input  logic   clk,
  input  logic   rst_n,
  rau_in_if.sink in_req,
  rau_out_if.source out_res
);
  import rau_pkg::*;

  logic push_valid, push_ready, pop_valid, pop_ready;
  raw_t push_data, pop_data;

  rau_front u_front (
    .clk(clk), .rst_n(rst_n), .in_req(in_req),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
  );

  rau_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
  );

  rau_back u_back (
    .clk(clk), .rst_n(rst_n),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
    .out_res(out_res)
  );

endmodule
